/* hw/rtl/mpd_pkg.sv */
// Shared types and constants for the mean pixel distance best-match block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mpd_pkg;
	localparam int ChannelBits = 8;
	localparam int CountBits   = 20;
	localparam int FracBits    = 8;
	localparam int IdBits      = 16;

	localparam int MeanBits  = ChannelBits + 1 + FracBits;
	localparam int SumBits   = MeanBits + CountBits + 1;
	localparam int CntBits   = CountBits + 1;
	localparam int SqBits    = 2 * ChannelBits + 2;
	// Root steps: one per bit pair of the squared distance plus the fraction pairs.
	localparam int SqrtSteps = SqBits / 2 + FracBits;
	localparam int SqxBits   = 2 * SqrtSteps;
	localparam int RemBits   = MeanBits + 3;
	localparam int DremBits  = CntBits + 1;

	localparam logic [MeanBits-1:0] MeanSat  = {MeanBits{1'b1}};
	localparam logic [CntBits-1:0]  CountMax = {CntBits{1'b1}};

	// One classified pixel pair waiting for the back end.
	typedef struct packed {
		logic [SqBits-1:0] sq;
		logic [IdBits-1:0] id;
		logic              last;
		logic              invalid;
		logic              first;
	} pair_t;
endpackage
`default_nettype wire

/* hw/rtl/mpd_if.sv */
// Handshake interfaces for pixel pair items and result items.
// Depends on mpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface mpd_pix_if;
	logic                          valid;
	logic                          ready;
	logic [mpd_pkg::ChannelBits-1:0] ref_red;
	logic [mpd_pkg::ChannelBits-1:0] ref_green;
	logic [mpd_pkg::ChannelBits-1:0] ref_blue;
	logic [mpd_pkg::ChannelBits-1:0] cand_red;
	logic [mpd_pkg::ChannelBits-1:0] cand_green;
	logic [mpd_pkg::ChannelBits-1:0] cand_blue;
	logic [mpd_pkg::IdBits-1:0]      candidate_id;
	logic                          last_pixel;
	logic                          candidate_invalid;
	logic                          first_of_set;
	modport source (output valid, ref_red, ref_green, ref_blue, cand_red, cand_green,
		cand_blue, candidate_id, last_pixel, candidate_invalid, first_of_set,
		input ready);
	modport sink (input valid, ref_red, ref_green, ref_blue, cand_red, cand_green,
		cand_blue, candidate_id, last_pixel, candidate_invalid, first_of_set,
		output ready);
endinterface

interface mpd_res_if;
	logic                         valid;
	logic                         ready;
	logic [mpd_pkg::MeanBits-1:0] mean_distance;
	logic [mpd_pkg::IdBits-1:0]   result_id;
	logic [mpd_pkg::MeanBits-1:0] best_distance;
	logic [mpd_pkg::IdBits-1:0]   best_id;
	logic                         best_valid;
	modport source (output valid, mean_distance, result_id, best_distance, best_id,
		best_valid, input ready);
	modport sink (input valid, mean_distance, result_id, best_distance, best_id,
		best_valid, output ready);
endinterface
`default_nettype wire

/* hw/rtl/mpd_front.sv */
// Front end: takes pixel pair items and forms the squared color distance.
// Depends on mpd_pkg and mpd_if.
`timescale 1ns / 1ps
`default_nettype none
module mpd_front (
	mpd_pix_if.sink               pix,
	input  wire logic             q_ready,
	output logic                  q_push,
	output mpd_pkg::pair_t        q_data
);
	logic [mpd_pkg::ChannelBits-1:0] dr, dg, db;
	logic [2*mpd_pkg::ChannelBits-1:0] sqr, sqg, sqb;

	// Absolute channel differences.
	always_comb begin
		dr = (pix.ref_red > pix.cand_red) ? pix.ref_red - pix.cand_red
			: pix.cand_red - pix.ref_red;
		dg = (pix.ref_green > pix.cand_green) ? pix.ref_green - pix.cand_green
			: pix.cand_green - pix.ref_green;
		db = (pix.ref_blue > pix.cand_blue) ? pix.ref_blue - pix.cand_blue
			: pix.cand_blue - pix.ref_blue;
	end

	// Squares and their sum.
	assign sqr = dr * dr;
	assign sqg = dg * dg;
	assign sqb = db * db;

	always_comb begin
		q_data.sq = mpd_pkg::SqBits'(sqr) + mpd_pkg::SqBits'(sqg) + mpd_pkg::SqBits'(sqb);
		q_data.id      = pix.candidate_id;
		q_data.last    = pix.last_pixel;
		q_data.invalid = pix.candidate_invalid;
		q_data.first   = pix.first_of_set;
	end

	assign pix.ready = q_ready;
	assign q_push    = pix.valid & q_ready;
endmodule
`default_nettype wire

/* hw/rtl/mpd_queue.sv */
// Two-entry queue between the front and back ends.
// Depends on mpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mpd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  mpd_pkg::pair_t      push_data,
	output logic                push_ready,
	input  wire logic           pop,
	output mpd_pkg::pair_t      pop_data,
	output logic                pop_valid
);
	mpd_pkg::pair_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];

	// Storage writes.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/mpd_back.sv */
// Back end: bit-serial square root, accumulation, serial division and best tracking.
// Depends on mpd_pkg and mpd_if.
`timescale 1ns / 1ps
`default_nettype none
module mpd_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  mpd_pkg::pair_t   q_data,
	input  wire logic        q_valid,
	output logic             q_pop,
	mpd_res_if.source        res
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQRT = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam int StepBits = $clog2(mpd_pkg::SumBits);

	logic [2:0]                       state_q;
	logic [StepBits-1:0]              step_q;
	logic [mpd_pkg::SqxBits-1:0]      sqx_q;
	logic [mpd_pkg::MeanBits-1:0]     root_q;
	logic [mpd_pkg::RemBits-1:0]      rem_q;
	logic [mpd_pkg::IdBits-1:0]       id_q;
	logic                             last_q;
	logic [mpd_pkg::SumBits-1:0]      sum_q;
	logic [mpd_pkg::CntBits-1:0]      cnt_q;
	logic                             inv_q;
	logic [mpd_pkg::SumBits-1:0]      dq_q;
	logic [mpd_pkg::DremBits-1:0]     drem_q;
	logic [mpd_pkg::MeanBits-1:0]     mean_q;
	logic [mpd_pkg::MeanBits-1:0]     best_mean_q;
	logic [mpd_pkg::IdBits-1:0]       best_id_q;
	logic                             best_found_q;
	logic                             out_valid_q;
	logic [mpd_pkg::MeanBits-1:0]     out_mean_q, out_best_q;
	logic [mpd_pkg::IdBits-1:0]       out_id_q, out_best_id_q;
	logic                             out_best_valid_q;

	logic [mpd_pkg::RemBits-1:0]  rem_sh, trial;
	logic                         root_bit;
	logic [mpd_pkg::SumBits-1:0]  sum_n;
	logic [mpd_pkg::CntBits-1:0]  cnt_n;
	logic                         inv_n;
	logic [mpd_pkg::DremBits-1:0] drem_sh, divisor;
	logic                         quo_bit;
	logic                         out_free;
	logic                         out_load;
	logic                         better;

	// One root step: bring down a bit pair and try the next root bit.
	always_comb begin
		rem_sh   = {rem_q[mpd_pkg::RemBits-3:0], sqx_q[mpd_pkg::SqxBits-1 -: 2]};
		trial    = {1'b0, root_q, 2'b01};
		root_bit = (rem_sh >= trial);
	end

	// Accumulator update, with the count saturating into the invalid flag.
	always_comb begin
		if (cnt_q == mpd_pkg::CountMax) begin
			sum_n = sum_q;
			cnt_n = cnt_q;
			inv_n = 1'b1;
		end else begin
			sum_n = sum_q + mpd_pkg::SumBits'(root_q);
			cnt_n = cnt_q + 1'b1;
			inv_n = inv_q;
		end
	end

	// One restoring division step.
	always_comb begin
		drem_sh = {drem_q[mpd_pkg::DremBits-2:0], dq_q[mpd_pkg::SumBits-1]};
		divisor = {1'b0, cnt_q};
		quo_bit = (drem_sh >= divisor);
	end

	assign out_free = !out_valid_q || res.ready;
	assign out_load = (state_q == ST_OUT) && out_free;
	assign better   = (mean_q < best_mean_q);
	assign q_pop    = (state_q == ST_IDLE) && q_valid;

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			step_q           <= '0;
			sum_q            <= '0;
			cnt_q            <= '0;
			inv_q            <= 1'b0;
			best_mean_q      <= mpd_pkg::MeanSat;
			best_id_q        <= '0;
			best_found_q     <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			// The output register fills on a hand-off and empties when taken.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						sqx_q  <= {q_data.sq, {(2*mpd_pkg::FracBits){1'b0}}};
						root_q <= '0;
						rem_q  <= '0;
						id_q   <= q_data.id;
						last_q <= q_data.last;
						if (q_data.invalid) inv_q <= 1'b1;
						if (q_data.first) begin
							best_mean_q  <= mpd_pkg::MeanSat;
							best_id_q    <= '0;
							best_found_q <= 1'b0;
						end
						step_q  <= StepBits'(mpd_pkg::SqrtSteps - 1);
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					sqx_q  <= sqx_q << 2;
					rem_q  <= root_bit ? rem_sh - trial : rem_sh;
					root_q <= {root_q[mpd_pkg::MeanBits-2:0], root_bit};
					step_q <= step_q - 1'b1;
					if (step_q == '0) state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q <= sum_n;
					cnt_q <= cnt_n;
					inv_q <= inv_n;
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (inv_n || cnt_n == '0) begin
						mean_q  <= mpd_pkg::MeanSat;
						state_q <= ST_OUT;
					end else begin
						dq_q    <= sum_n;
						drem_q  <= '0;
						step_q  <= StepBits'(mpd_pkg::SumBits - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					drem_q <= quo_bit ? drem_sh - divisor : drem_sh;
					dq_q   <= {dq_q[mpd_pkg::SumBits-2:0], quo_bit};
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						// Clamp a valid mean below the saturated code.
						if ({dq_q[mpd_pkg::SumBits-2:0], quo_bit} >=
							mpd_pkg::SumBits'(mpd_pkg::MeanSat)) begin
							mean_q <= mpd_pkg::MeanSat - 1'b1;
						end else begin
							mean_q <= dq_q[mpd_pkg::MeanBits-2:0] == '0 && quo_bit == 1'b0
								? '0 : {dq_q[mpd_pkg::MeanBits-2:0], quo_bit};
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_mean_q       <= mean_q;
						out_id_q         <= id_q;
						out_best_q       <= better ? mean_q : best_mean_q;
						out_best_id_q    <= better ? id_q : best_id_q;
						out_best_valid_q <= better | best_found_q;
						if (better) begin
							best_mean_q  <= mean_q;
							best_id_q    <= id_q;
							best_found_q <= 1'b1;
						end
						sum_q   <= '0;
						cnt_q   <= '0;
						inv_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid         = out_valid_q;
	assign res.mean_distance = out_mean_q;
	assign res.result_id     = out_id_q;
	assign res.best_distance = out_best_q;
	assign res.best_id       = out_best_id_q;
	assign res.best_valid    = out_best_valid_q;
endmodule
`default_nettype wire

/* hw/rtl/mean_pixel_distance_best_match.sv */
// Channel | Dir | Item
// pix     | in  | reference and candidate RGB pixel pair with candidate flags
// res     | out | candidate mean distance with the best match of the set
//
// In the back end a pixel pair is dispatched, runs 17 root steps and is accumulated;
// the pair that closes a valid candidate then passes through the serial divider before
// the result is handed off. The root and divider are bit-serial, one pair at a time.
// The front end squares pairs combinationally and pushes them into a two-entry queue.
// Reset clears the accumulators and sets the best mean to the saturated code.
// A stalled result waits in its output register while the back end keeps working.
// Depends on mpd_pkg, mpd_if, mpd_front, mpd_queue, mpd_back.
`timescale 1ns / 1ps
`default_nettype none
module mean_pixel_distance_best_match (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mpd_pix_if.sink    pix,
	mpd_res_if.source  res
);
	mpd_pkg::pair_t push_data, pop_data;
	logic push, push_ready, pop, pop_valid;

	// Front end: classify and square.
	mpd_front u_front (
		.pix     (pix),
		.q_ready (push_ready),
		.q_push  (push),
		.q_data  (push_data)
	);

	// Queue between the two ends.
	mpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid)
	);

	// Back end: root, mean and best match.
	mpd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (pop_data),
		.q_valid (pop_valid),
		.q_pop   (pop),
		.res     (res)
	);

`ifndef SYNTHESIS
	// The best of the set never exceeds the mean just reported.
	a_best_le_mean: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.best_distance <= res.mean_distance)
		else $error("best distance above current mean");
	// A valid best never carries the saturated code.
	a_best_valid_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.best_valid |-> res.best_distance != mpd_pkg::MeanSat)
		else $error("valid best holds saturated code");
	// Without a valid best, the best fields hold their cleared values.
	a_best_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.best_valid |-> res.best_distance == mpd_pkg::MeanSat
			&& res.best_id == '0)
		else $error("best fields not cleared");
`endif
endmodule
`default_nettype wire
